[rtl/hbsd_pkg.sv]
// Package for the bit-serial Huffman decoder: sizes, opcodes, beat structs
// and the small compare helpers used by the table cells.
// Depends on nothing.
`timescale 1ns / 1ps

package hbsd_pkg;

  // Block sizes.
  localparam int MAX_CODE_LEN  = 32;
  localparam int TABLE_ENTRIES = 256;

  // Fixed field widths.
  localparam int OP_W   = 2;
  localparam int SYM_W  = 8;
  localparam int LEN_W  = 6;
  localparam int CODE_W = 32;

  // Pending counter holds 0 .. MAX_CODE_LEN.
  localparam int CNT_W      = $clog2(MAX_CODE_LEN + 1);
  localparam int LCMP_W     = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int CODE_CMP_W = (CODE_W < MAX_CODE_LEN) ? CODE_W : MAX_CODE_LEN;

  // Table split into a row of cells with a few slots each.
  localparam int CELL_SLOTS = 8;
  localparam int SLOT_W     = $clog2(CELL_SLOTS);
  localparam int CELL_ID_W  = SYM_W - SLOT_W;
  localparam int NUM_CELLS  = (TABLE_ENTRIES + CELL_SLOTS - 1) / CELL_SLOTS;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_DECODE = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_RESULT
  } state_t;

  // Input beat.
  typedef struct packed {
    opcode_t             opcode;
    logic [SYM_W-1:0]    entry_symbol;
    logic [LEN_W-1:0]    entry_length;
    logic [CODE_W-1:0]   entry_code;
    logic                stream_bit;
  } req_item_t;

  // Output beat.
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             decode_error;
  } rsp_item_t;

  // Table write control broadcast to every cell.
  typedef struct packed {
    logic              clear;
    logic              load;
    logic [SYM_W-1:0]  sym;
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } tbl_ctl_t;

  // Search token handed from cell to cell.
  typedef struct packed {
    logic                    valid;
    logic [MAX_CODE_LEN-1:0] bits;
    logic [CNT_W-1:0]        count;
    logic                    found;
    logic [SYM_W-1:0]        sym;
  } token_t;

  // True when a symbol addresses a slot that exists.
  function automatic logic in_table(input logic [SYM_W-1:0] sym);
    return (int'(sym) < TABLE_ENTRIES);
  endfunction

  // Stored length equals the pending count.
  function automatic logic len_match(input logic [LEN_W-1:0] len,
                                     input logic [CNT_W-1:0] count);
    return (LCMP_W'(len) == LCMP_W'(count));
  endfunction

  // Stored code brought to the pending string width.
  function automatic logic [MAX_CODE_LEN-1:0] code_ext(input logic [CODE_W-1:0] code);
    logic [MAX_CODE_LEN-1:0] r;
    r = '0;
    for (int i = 0; i < CODE_CMP_W; i++) begin
      r[i] = code[i];
    end
    return r;
  endfunction

  // Ones in the low count bits.
  function automatic logic [MAX_CODE_LEN-1:0] low_mask(input logic [CNT_W-1:0] count);
    logic [MAX_CODE_LEN-1:0] m;
    for (int i = 0; i < MAX_CODE_LEN; i++) begin
      m[i] = (i < int'(count));
    end
    return m;
  endfunction

endpackage

[rtl/hbsd_cell.sv]
// One cell of the code table: a few slots, their compare logic and the
// token register that hands the search to the next cell.
// Depends on hbsd_pkg.
`timescale 1ns / 1ps

module hbsd_cell (
  input  logic                           clk,
  input  logic                           rst,
  input  logic [hbsd_pkg::CELL_ID_W-1:0] cell_id,
  input  hbsd_pkg::tbl_ctl_t             ctl,
  input  hbsd_pkg::token_t               tok_prev,
  output hbsd_pkg::token_t               tok
);

  logic [hbsd_pkg::CELL_SLOTS-1:0] slot_valid;
  logic [hbsd_pkg::LEN_W-1:0]      slot_len  [hbsd_pkg::CELL_SLOTS];
  logic [hbsd_pkg::CODE_W-1:0]     slot_code [hbsd_pkg::CELL_SLOTS];

  logic                            we;
  logic [hbsd_pkg::SLOT_W-1:0]     wslot;
  logic [hbsd_pkg::CELL_SLOTS-1:0] hit;
  logic [hbsd_pkg::SLOT_W-1:0]     pick;
  hbsd_pkg::token_t                tok_next;

  // A load lands here when the upper symbol bits name this cell.
  assign wslot = ctl.sym[hbsd_pkg::SLOT_W-1:0];
  assign we    = ctl.load && (ctl.sym[hbsd_pkg::SYM_W-1:hbsd_pkg::SLOT_W] == cell_id)
                 && hbsd_pkg::in_table(ctl.sym);

  // Valid bits clear at reset and on a table clear.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      slot_valid <= '0;
    end else if (we) begin
      slot_valid[wslot] <= 1'b1;
    end
  end

  // Slot payload.
  always_ff @(posedge clk) begin
    if (we) begin
      slot_len[wslot]  <= ctl.len;
      slot_code[wslot] <= ctl.code;
    end
  end

  // Compare every slot against the token, lowest slot wins.
  always_comb begin
    for (int j = 0; j < hbsd_pkg::CELL_SLOTS; j++) begin
      hit[j] = slot_valid[j]
               && hbsd_pkg::len_match(slot_len[j], tok_prev.count)
               && ((hbsd_pkg::code_ext(slot_code[j]) & hbsd_pkg::low_mask(tok_prev.count))
                   == tok_prev.bits);
    end
    pick = '0;
    for (int j = hbsd_pkg::CELL_SLOTS - 1; j >= 0; j--) begin
      if (hit[j]) begin
        pick = hbsd_pkg::SLOT_W'(j);
      end
    end
    tok_next = tok_prev;
    if (tok_prev.valid && !tok_prev.found && (|hit)) begin
      tok_next.found = 1'b1;
      tok_next.sym   = {cell_id, pick};
    end
  end

  // Token register toward the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else begin
      tok <= tok_next;
    end
  end

endmodule

[rtl/huffman_bit_serial_decoder.sv]
// Top level of the bit-serial Huffman decoder: handshakes, pending bit
// string, result register and the row of table cells.
// Depends on hbsd_pkg and hbsd_cell.
`timescale 1ns / 1ps

// Usage
// The req channel carries beats with an opcode: clear the table, load one
// entry (symbol, length, right-aligned code) or feed one compressed bit.
// The rsp channel carries one beat per decoded symbol, or an error beat
// (decode_error set, symbol zero) when MAX_CODE_LEN bits pass unmatched.
// Clear and load beats give no result.
// A decode beat appends its bit and sends a search token down a row of
// NUM_CELLS cells, CELL_SLOTS table slots each, one cell per cycle. Any
// result beat and the next req beat wait for the token's walk along
// the row. A found result is written to the rsp register as the token
// leaves the row. A result held in the rsp register does not block clear
// or load beats; a new result waits in a hold register while rsp_stall
// is high, and req stays stalled until it moves.
// Reset empties the table and the pending string and drops rsp_valid; it
// needs no clearing pass.

module huffman_bit_serial_decoder (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  hbsd_pkg::req_item_t  req_data,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output hbsd_pkg::rsp_item_t  rsp_data
);

  hbsd_pkg::state_t                  state, state_next;
  logic [hbsd_pkg::MAX_CODE_LEN-1:0] pending_bits, pending_bits_next;
  logic [hbsd_pkg::CNT_W-1:0]        pending_count, pending_count_next;
  hbsd_pkg::token_t                  tok_head, tok_head_next;
  hbsd_pkg::rsp_item_t               hold, hold_next;
  hbsd_pkg::rsp_item_t               rsp_data_next;
  logic                              rsp_valid_next;
  hbsd_pkg::rsp_item_t               res;
  logic                              res_any;
  logic                              accept;
  logic                              rsp_free;
  hbsd_pkg::tbl_ctl_t                ctl;
  hbsd_pkg::token_t                  chain [hbsd_pkg::NUM_CELLS];
  hbsd_pkg::token_t                  tail;
  logic [hbsd_pkg::NUM_CELLS:0]      tok_live;

  assign req_stall = (state != hbsd_pkg::ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign rsp_free  = !rsp_valid || !rsp_stall;

  // Table writes go to all cells in the cycle the beat is taken.
  always_comb begin
    ctl.clear = accept && (req_data.opcode == hbsd_pkg::OP_CLEAR);
    ctl.load  = accept && (req_data.opcode == hbsd_pkg::OP_LOAD);
    ctl.sym   = req_data.entry_symbol;
    ctl.len   = req_data.entry_length;
    ctl.code  = req_data.entry_code;
  end

  // Row of table cells.
  for (genvar g = 0; g < hbsd_pkg::NUM_CELLS; g++) begin : g_cell
    if (g == 0) begin : g_first
      hbsd_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .cell_id  (hbsd_pkg::CELL_ID_W'(g)),
        .ctl      (ctl),
        .tok_prev (tok_head),
        .tok      (chain[g])
      );
    end else begin : g_next
      hbsd_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .cell_id  (hbsd_pkg::CELL_ID_W'(g)),
        .ctl      (ctl),
        .tok_prev (chain[g-1]),
        .tok      (chain[g])
      );
    end
  end

  assign tail = chain[hbsd_pkg::NUM_CELLS-1];

  // Result from the token at the end of the row.
  always_comb begin
    res_any             = tail.found
                          || (tail.count == hbsd_pkg::CNT_W'(hbsd_pkg::MAX_CODE_LEN));
    res.symbol          = tail.found ? tail.sym : '0;
    res.decode_error    = !tail.found;
  end

  // Next state, pending string and result path.
  always_comb begin
    state_next         = state;
    pending_bits_next  = pending_bits;
    pending_count_next = pending_count;
    tok_head_next      = tok_head;
    tok_head_next.valid = 1'b0;
    hold_next          = hold;
    rsp_data_next      = rsp_data;
    rsp_valid_next     = rsp_valid && rsp_stall;

    case (state)
      hbsd_pkg::ST_IDLE: begin
        if (accept) begin
          case (req_data.opcode)
            hbsd_pkg::OP_CLEAR: begin
              pending_bits_next  = '0;
              pending_count_next = '0;
            end
            hbsd_pkg::OP_DECODE: begin
              pending_bits_next  = {pending_bits[hbsd_pkg::MAX_CODE_LEN-2:0],
                                    req_data.stream_bit};
              pending_count_next = pending_count + hbsd_pkg::CNT_W'(1);
              tok_head_next.valid = 1'b1;
              tok_head_next.bits  = pending_bits_next;
              tok_head_next.count = pending_count_next;
              tok_head_next.found = 1'b0;
              tok_head_next.sym   = '0;
              state_next          = hbsd_pkg::ST_SEARCH;
            end
            default: begin
            end
          endcase
        end
      end
      hbsd_pkg::ST_SEARCH: begin
        if (tail.valid) begin
          if (res_any) begin
            pending_bits_next  = '0;
            pending_count_next = '0;
            if (rsp_free) begin
              rsp_data_next  = res;
              rsp_valid_next = 1'b1;
              state_next     = hbsd_pkg::ST_IDLE;
            end else begin
              hold_next  = res;
              state_next = hbsd_pkg::ST_RESULT;
            end
          end else begin
            state_next = hbsd_pkg::ST_IDLE;
          end
        end
      end
      hbsd_pkg::ST_RESULT: begin
        if (rsp_free) begin
          rsp_data_next  = hold;
          rsp_valid_next = 1'b1;
          state_next     = hbsd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = hbsd_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= hbsd_pkg::ST_IDLE;
      pending_bits  <= '0;
      pending_count <= '0;
      rsp_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      pending_bits  <= pending_bits_next;
      pending_count <= pending_count_next;
      rsp_valid     <= rsp_valid_next;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_head.valid <= 1'b0;
    end else begin
      tok_head <= tok_head_next;
    end
    hold     <= hold_next;
    rsp_data <= rsp_data_next;
  end

  // Live tokens, for checking.
  always_comb begin
    tok_live[0] = tok_head.valid;
    for (int k = 0; k < hbsd_pkg::NUM_CELLS; k++) begin
      tok_live[k+1] = chain[k].valid;
    end
  end

  // At most one search token is ever in flight.
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $countones(tok_live) <= 1)
    else $error("more than one search token in the cell row");

  // A token leaves the row only while a search is pending.
  a_tail_in_search: assert property (@(posedge clk) disable iff (rst)
    tail.valid |-> (state == hbsd_pkg::ST_SEARCH))
    else $error("search token arrived outside a search");

  // The pending string never runs past the longest code.
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    pending_count <= hbsd_pkg::CNT_W'(hbsd_pkg::MAX_CODE_LEN))
    else $error("pending count beyond maximum code length");

  // An error beat carries symbol zero.
  a_error_symbol: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_data.decode_error) |-> (rsp_data.symbol == '0))
    else $error("error beat with nonzero symbol");

endmodule

[bench/tb_top.sv]
// Self-checking bench for the bit-serial Huffman decoder: directed table beats,
// then random code tables with encoded bit streams, checked against a predictor.
// Depends on hbsd_pkg and huffman_bit_serial_decoder.
`timescale 1ns / 1ps

module tb_top;

  // Opcode the block leaves unused; it must be ignored.
  localparam logic [hbsd_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_BEATS = 780;
  localparam int DRAIN_CYCLES = 2 * (hbsd_pkg::NUM_CELLS + 1);

  // One row of the directed stimulus table.
  typedef struct {
    hbsd_pkg::req_item_t req;
    int                  reps;
    bit                  typed;
    bit                  has_res;
    hbsd_pkg::rsp_item_t res;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  hbsd_pkg::req_item_t req_data = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  hbsd_pkg::rsp_item_t rsp_data;

  // Predictor state: code table and the pending bit string.
  logic                        tbl_valid [hbsd_pkg::TABLE_ENTRIES];
  logic [hbsd_pkg::LEN_W-1:0]  tbl_len   [hbsd_pkg::TABLE_ENTRIES];
  logic [hbsd_pkg::CODE_W-1:0] tbl_code  [hbsd_pkg::TABLE_ENTRIES];
  logic [63:0]                 bit_str = '0;
  int                          bit_cnt = 0;

  // Symbols and errors the decoder still owes, oldest first.
  hbsd_pkg::rsp_item_t owed_symbols[$];
  int        mismatches = 0;
  bit        idle_on = 1'b1;
  bit        stall_on = 1'b1;
  int        stall_left = 0;
  int        beats_sent = 0;

  huffman_bit_serial_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_data  (rsp_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
  end

  // Queue one result the decoder has to deliver.
  function automatic void owe_result(input hbsd_pkg::rsp_item_t r);
    owed_symbols = {owed_symbols, r};
  endfunction

  // Advance the predictor by one accepted beat; returns 1 when a result is due.
  function automatic bit huff_decode_step(input hbsd_pkg::req_item_t it,
                                          output hbsd_pkg::rsp_item_t res);
    logic [63:0] m;
    res = '0;
    case (it.opcode)
      hbsd_pkg::OP_CLEAR: begin
        foreach (tbl_valid[i]) tbl_valid[i] = 1'b0;
        bit_str = '0;
        bit_cnt = 0;
        return 1'b0;
      end
      hbsd_pkg::OP_LOAD: begin
        if (int'(it.entry_symbol) < hbsd_pkg::TABLE_ENTRIES) begin
          tbl_valid[it.entry_symbol] = 1'b1;
          tbl_len[it.entry_symbol]   = it.entry_length;
          tbl_code[it.entry_symbol]  = it.entry_code;
        end
        return 1'b0;
      end
      hbsd_pkg::OP_DECODE: begin
        bit_str = {bit_str[62:0], it.stream_bit};
        bit_cnt++;
        m = (64'd1 << bit_cnt) - 64'd1;
        // Lowest slot wins when the table is not prefix-free.
        for (int i = 0; i < hbsd_pkg::TABLE_ENTRIES; i++) begin
          if (tbl_valid[i] && int'(tbl_len[i]) == bit_cnt &&
              ({32'd0, tbl_code[i]} & m) == (bit_str & m)) begin
            res.symbol = hbsd_pkg::SYM_W'(i);
            bit_str = '0;
            bit_cnt = 0;
            return 1'b1;
          end
        end
        if (bit_cnt >= hbsd_pkg::MAX_CODE_LEN) begin
          res.decode_error = 1'b1;
          bit_str = '0;
          bit_cnt = 0;
          return 1'b1;
        end
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic hbsd_pkg::req_item_t rand_req(input logic [hbsd_pkg::OP_W-1:0] op);
    hbsd_pkg::req_item_t it;
    it.opcode       = hbsd_pkg::opcode_t'(op);
    it.entry_symbol = hbsd_pkg::SYM_W'($urandom);
    it.entry_length = hbsd_pkg::LEN_W'($urandom);
    it.entry_code   = hbsd_pkg::CODE_W'($urandom);
    it.stream_bit   = 1'($urandom);
    return it;
  endfunction

  function automatic dir_row_t mk_row(input logic [hbsd_pkg::OP_W-1:0] op, input int sym,
                                      input int len,
                                      input logic [hbsd_pkg::CODE_W-1:0] code,
                                      input bit sbit, input int reps, input bit typed,
                                      input bit has_res, input int rsym, input bit rerr);
    dir_row_t row;
    row.req.opcode           = hbsd_pkg::opcode_t'(op);
    row.req.entry_symbol     = hbsd_pkg::SYM_W'(sym);
    row.req.entry_length     = hbsd_pkg::LEN_W'(len);
    row.req.entry_code       = code;
    row.req.stream_bit       = sbit;
    row.reps                 = reps;
    row.typed                = typed;
    row.has_res              = has_res;
    row.res.symbol           = hbsd_pkg::SYM_W'(rsym);
    row.res.decode_error     = rerr;
    return row;
  endfunction

  // Drive one request beat, with a random idle gap ahead of it, and wait
  // for the handshake. Starts and ends at a falling edge.
  task automatic send_beat(input hbsd_pkg::req_item_t it, input bit use_model);
    hbsd_pkg::rsp_item_t res;
    int gap;
    gap = idle_on ? $urandom_range(0, 4) : 0;
    if ($urandom_range(0, 39) == 0) idle_on = !idle_on;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_data  <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    if (huff_decode_step(it, res) && use_model) owe_result(res);
    if (it.opcode != OP_UNUSED) beats_sent++;
    @(negedge clk);
  endtask

  task automatic feed_bit(input logic sbit);
    hbsd_pkg::req_item_t it;
    it = rand_req(hbsd_pkg::OP_DECODE);
    it.stream_bit = sbit;
    send_beat(it, 1'b1);
  endtask

  // The result side stalls while a drawn wait is still running.
  always @(negedge clk) begin
    rsp_stall <= (stall_left > 0);
  end

  // Compare each accepted result beat with the oldest owed one, then draw
  // the wait before the next one.
  always @(posedge clk) begin
    hbsd_pkg::rsp_item_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (owed_symbols.size() == 0) begin
        $error("result beat with none expected: symbol %0d decode_error %0b",
               rsp_data.symbol, rsp_data.decode_error);
        mismatches++;
      end else begin
        want = owed_symbols.pop_front();
        if (rsp_data.symbol !== want.symbol) begin
          $error("symbol: expected %0d, got %0d", want.symbol, rsp_data.symbol);
          mismatches++;
        end
        if (rsp_data.decode_error !== want.decode_error) begin
          $error("decode_error: expected %0b, got %0b", want.decode_error,
                 rsp_data.decode_error);
          mismatches++;
        end
      end
      stall_left = stall_on ? $urandom_range(0, 4) : 0;
      if ($urandom_range(0, 29) == 0) stall_on = !stall_on;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end
  end

  initial begin
    dir_row_t                    rows[$];
    hbsd_pkg::req_item_t         it;
    logic [hbsd_pkg::CODE_W-1:0] lcode [64];
    int                          llen  [64];
    logic [hbsd_pkg::CODE_W-1:0] m32;
    int n, k, j, b, nleaf, target, maxd, found, drop, s0, stride, mode, nsym;
    bit chain;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed part. Typed rows carry their result on the last repeat.
    rows = {rows, mk_row(hbsd_pkg::OP_DECODE, 0, 0, 0, 1, 31, 1, 0, 0, 0)};  // empty table
    rows = {rows, mk_row(hbsd_pkg::OP_DECODE, 0, 0, 0, 0, 1, 1, 1, 0, 1)};   // no match
    rows = {rows, mk_row(hbsd_pkg::OP_LOAD, 255, 1, 32'hFFFF_FFFF, 0, 1, 1, 0, 0, 0)};
    rows = {rows, mk_row(hbsd_pkg::OP_DECODE, 0, 0, 0, 1, 1, 1, 1, 255, 0)};
    rows = {rows, mk_row(hbsd_pkg::OP_LOAD, 0, 1, 32'h0, 0, 1, 1, 0, 0, 0)};
    rows = {rows, mk_row(hbsd_pkg::OP_DECODE, 0, 0, 0, 0, 1, 1, 1, 0, 0)};
    // A second one-bit code equal to slot 255: the lower slot must win.
    rows = {rows, mk_row(hbsd_pkg::OP_LOAD, 7, 1, 32'h1234_5679, 0, 1, 0, 0, 0, 0)};
    rows = {rows, mk_row(hbsd_pkg::OP_DECODE, 0, 0, 0, 1, 1, 0, 0, 0, 0)};
    rows = {rows, mk_row(hbsd_pkg::OP_CLEAR, 0, 0, 0, 0, 1, 1, 0, 0, 0)};
    rows = {rows, mk_row(hbsd_pkg::OP_DECODE, 0, 0, 0, 1, 1, 1, 0, 0, 0)};
    // Load between bits keeps the pending string.
    rows = {rows, mk_row(hbsd_pkg::OP_LOAD, 3, 2, 32'hFFFF_FFFE, 0, 1, 0, 0, 0, 0)};
    rows = {rows, mk_row(hbsd_pkg::OP_DECODE, 0, 0, 0, 0, 1, 0, 0, 0, 0)};
    // Zero length and over-long entries never match.
    rows = {rows, mk_row(hbsd_pkg::OP_LOAD, 4, 0, 32'h0, 0, 1, 0, 0, 0, 0)};
    rows = {rows, mk_row(hbsd_pkg::OP_LOAD, 5, 33, 32'h0, 0, 1, 0, 0, 0, 0)};
    rows = {rows, mk_row(hbsd_pkg::OP_LOAD, 6, 63, 32'hFFFF_FFFF, 0, 1, 0, 0, 0, 0)};
    rows = {rows, mk_row(OP_UNUSED, 9, 1, 32'h0, 1, 1, 1, 0, 0, 0)};
    rows = {rows, mk_row(hbsd_pkg::OP_DECODE, 0, 0, 0, 0, 31, 0, 0, 0, 0)};
    // Full-length code completes on the same bit as the length limit.
    rows = {rows, mk_row(hbsd_pkg::OP_LOAD, 200, 32, 32'h0000_0001, 0, 1, 0, 0, 0, 0)};
    rows = {rows, mk_row(hbsd_pkg::OP_DECODE, 0, 0, 0, 1, 1, 0, 0, 0, 0)};
    rows = {rows, mk_row(hbsd_pkg::OP_DECODE, 0, 0, 0, 1, 32, 0, 0, 0, 0)};
    // Reload of a slot replaces the earlier entry.
    rows = {rows, mk_row(hbsd_pkg::OP_LOAD, 3, 1, 32'h0, 0, 1, 0, 0, 0, 0)};
    rows = {rows, mk_row(hbsd_pkg::OP_DECODE, 0, 0, 0, 0, 1, 0, 0, 0, 0)};

    foreach (rows[r]) begin
      for (n = 0; n < rows[r].reps; n++) begin
        if (rows[r].typed && rows[r].has_res && n == rows[r].reps - 1)
          owe_result(rows[r].res);
        send_beat(rows[r].req, !rows[r].typed);
      end
    end

    // Random part: mostly complete prefix-free tables and encoded streams.
    beats_sent = 0;
    while (beats_sent < RANDOM_BEATS) begin
      mode = $urandom_range(0, 9);
      if (mode <= 6) begin
        if ($urandom_range(0, 5) != 0) send_beat(rand_req(hbsd_pkg::OP_CLEAR), 1'b1);
        // Grow a code tree by splitting leaves; a chain reaches full length.
        chain = ($urandom_range(0, 3) == 0);
        if (chain) begin
          target = $urandom_range(20, 33);
          maxd   = hbsd_pkg::MAX_CODE_LEN;
        end else begin
          target = $urandom_range(2, 20);
          maxd   = $urandom_range(3, 10);
        end
        nleaf = 2;
        lcode[0] = '0;
        llen[0]  = 1;
        lcode[1] = 32'd1;
        llen[1]  = 1;
        while (nleaf < target) begin
          j = chain ? nleaf - 1 : $urandom_range(0, nleaf - 1);
          found = -1;
          for (k = 0; k < nleaf; k++)
            if (found < 0 && llen[(j + k) % nleaf] < maxd) found = (j + k) % nleaf;
          if (found < 0) break;
          lcode[nleaf]  = {lcode[found][hbsd_pkg::CODE_W-2:0], 1'b1};
          llen[nleaf]   = llen[found] + 1;
          lcode[found]  = {lcode[found][hbsd_pkg::CODE_W-2:0], 1'b0};
          llen[found]++;
          nleaf++;
        end
        // Distinct symbols through an odd stride; a broken table loses one leaf.
        s0     = $urandom_range(0, 255);
        stride = 2 * $urandom_range(0, 127) + 1;
        drop   = (mode == 6) ? $urandom_range(0, nleaf - 1) : -1;
        j      = $urandom_range(0, nleaf - 1);
        for (n = 0; n < nleaf; n++) begin
          k = (j + n) % nleaf;
          if (k != drop) begin
            m32 = (llen[k] >= hbsd_pkg::CODE_W) ? '1 : ((32'd1 << llen[k]) - 32'd1);
            it = rand_req(hbsd_pkg::OP_LOAD);
            it.entry_symbol = hbsd_pkg::SYM_W'(s0 + k * stride);
            it.entry_length = hbsd_pkg::LEN_W'(llen[k]);
            it.entry_code   = (hbsd_pkg::CODE_W'($urandom) & ~m32) | lcode[k];
            send_beat(it, 1'b1);
          end
        end
        nsym = chain ? $urandom_range(3, 8) : $urandom_range(5, 20);
        for (n = 0; n < nsym; n++) begin
          k = $urandom_range(0, nleaf - 1);
          for (b = llen[k] - 1; b >= 0; b--) begin
            if ($urandom_range(0, 29) == 0) send_beat(rand_req(OP_UNUSED), 1'b1);
            feed_bit(lcode[k][b]);
          end
        end
        if (mode == 6)
          for (n = $urandom_range(20, 40); n > 0; n--) feed_bit(1'($urandom));
      end else if (mode <= 8) begin
        // Noise over every opcode and every field value.
        for (n = 0; n < 20; n++) begin
          case ($urandom_range(0, 7))
            0:       it = rand_req(hbsd_pkg::OP_CLEAR);
            1, 2:    it = rand_req(hbsd_pkg::OP_LOAD);
            3:       it = rand_req(OP_UNUSED);
            default: it = rand_req(hbsd_pkg::OP_DECODE);
          endcase
          send_beat(it, 1'b1);
        end
      end else begin
        // Overlapping short codes, so several slots can match at once.
        send_beat(rand_req(hbsd_pkg::OP_CLEAR), 1'b1);
        for (n = $urandom_range(2, 8); n > 0; n--) begin
          it = rand_req(hbsd_pkg::OP_LOAD);
          it.entry_length = hbsd_pkg::LEN_W'($urandom_range(1, 4));
          send_beat(it, 1'b1);
        end
        for (n = 0; n < 30; n++) feed_bit(1'($urandom));
      end
    end

    req_valid <= 1'b0;
    while (owed_symbols.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog on the whole run.
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[filelist.f]
rtl/hbsd_pkg.sv
rtl/hbsd_cell.sv
rtl/huffman_bit_serial_decoder.sv
bench/tb_top.sv
